@@ rtl/esd_pkg.sv @@
package esd_pkg;

    localparam int DEF_MAX_BUFFER_SIZE = 4096;
    localparam int BUF_W  = 13;
    localparam int LEN_W  = 12;
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [0:0] REG_BUFFER_SIZE = 1'b0;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_X      = 8'h78;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_7      = 8'h37;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LF_    = 8'h66;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UF     = 8'h46;
    localparam logic [7:0] BYTE_LF   = 8'h0A;
    localparam logic [7:0] BYTE_CR   = 8'h0D;
    localparam logic [7:0] BYTE_TAB  = 8'h09;
    localparam logic [7:0] BYTE_ESC  = 8'h1B;

    typedef struct packed {
        logic [7:0]       data_byte;
        logic             byte_valid;
        logic             string_done;
        logic [LEN_W-1:0] decoded_length;
        logic             truncated;
    } t_res;

    typedef struct packed {
        logic two;
        t_res r0;
        t_res r1;
    } t_entry;

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CH_0 && c <= CH_9) || (c >= CH_LA && c <= CH_LF_) ||
               (c >= CH_UA && c <= CH_UF);
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] v;
        if (c >= CH_0 && c <= CH_9) begin
            v = c - CH_0;
        end else if (c >= CH_LA && c <= CH_LF_) begin
            v = c - CH_LA + 8'd10;
        end else begin
            v = c - CH_UA + 8'd10;
        end
        return v[3:0];
    endfunction

endpackage

@@ rtl/esd_front.sv @@
module esd_front #(
    parameter int MAX_BUFFER_SIZE = esd_pkg::DEF_MAX_BUFFER_SIZE
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [7:0]                 i_char,
    input  logic                       i_eos,
    input  logic [esd_pkg::BUF_W-1:0]  i_buffer_size,
    output logic                       o_push,
    output esd_pkg::t_entry            o_entry,
    input  logic                       i_full
);
    import esd_pkg::*;

    localparam int LIM_W = $clog2(MAX_BUFFER_SIZE + 1);
    localparam int CW    = ((LIM_W > BUF_W) ? LIM_W : BUF_W) + 1;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_BUFFER_SIZE);

    localparam logic [2:0] MODE_TEXT = 3'd0;
    localparam logic [2:0] MODE_ESC  = 3'd1;
    localparam logic [2:0] MODE_HEX0 = 3'd2;
    localparam logic [2:0] MODE_HEX1 = 3'd3;
    localparam logic [2:0] MODE_OCT1 = 3'd4;
    localparam logic [2:0] MODE_OCT2 = 3'd5;

    logic [2:0]       r_mode, n_mode;
    logic [7:0]       r_pend, n_pend;
    logic [LIM_W-1:0] r_count, n_count;
    logic             r_lim, n_lim;

    logic [CW-1:0] limit;
    logic [CW-1:0] cnt_ext;
    logic          accept;
    logic          e0_v, tc_go, tc_v;
    logic [7:0]    e0_d;
    logic          is_oct;
    logic          fin;
    logic [CW-1:0] after_e0;
    logic [CW-1:0] len_c;
    logic [8:0]    oct9;
    t_res          byte0, byte1, done_res;
    logic          n_res_any, n_res_two;

    assign accept  = i_valid && !i_full;
    assign o_ready = !i_full;
    assign cnt_ext = CW'(r_count);
    assign limit   = (CW'(i_buffer_size) > MAX_C) ? MAX_C : CW'(i_buffer_size);
    assign is_oct  = i_char inside {[CH_0:CH_7]};
    assign fin     = i_eos || (i_char == CH_NUL);
    assign oct9    = {r_pend[5:0], i_char[2:0]};

    always_comb begin
        n_mode   = r_mode;
        n_pend   = r_pend;
        n_count  = r_count;
        n_lim    = r_lim;
        e0_v     = 1'b0;
        e0_d     = r_pend;
        tc_go    = 1'b0;
        tc_v     = 1'b0;
        after_e0 = cnt_ext;
        len_c    = cnt_ext;
        byte0    = '0;
        byte1    = '0;
        done_res = '0;
        n_res_any = 1'b0;
        n_res_two = 1'b0;

        if (fin) begin
            if (r_mode == MODE_HEX1 || r_mode == MODE_OCT1 || r_mode == MODE_OCT2) begin
                e0_v = 1'b1;
            end
            len_c = cnt_ext + CW'(e0_v);
            done_res.string_done    = 1'b1;
            done_res.decoded_length = len_c[LEN_W-1:0];
            done_res.truncated      = r_lim;
            n_mode  = MODE_TEXT;
            n_pend  = '0;
            n_count = '0;
            n_lim   = 1'b0;
            n_res_any = 1'b1;
            byte0.data_byte  = r_pend;
            byte0.byte_valid = 1'b1;
            if (e0_v) begin
                n_res_two = 1'b1;
            end
        end else if (!r_lim) begin
            case (r_mode)
                MODE_ESC: begin
                    n_mode = MODE_TEXT;
                    e0_v   = 1'b1;
                    case (i_char)
                        CH_BSLASH: e0_d = CH_BSLASH;
                        CH_QUOTE:  e0_d = CH_QUOTE;
                        CH_N:      e0_d = BYTE_LF;
                        CH_R:      e0_d = BYTE_CR;
                        CH_T:      e0_d = BYTE_TAB;
                        CH_E:      e0_d = BYTE_ESC;
                        CH_X: begin
                            e0_v   = 1'b0;
                            n_mode = MODE_HEX0;
                        end
                        default: begin
                            e0_v = 1'b0;
                            if (is_oct) begin
                                n_pend = {5'd0, i_char[2:0]};
                                n_mode = MODE_OCT1;
                            end else begin
                                tc_go = 1'b1;
                            end
                        end
                    endcase
                end
                MODE_HEX0: begin
                    if (is_hex(i_char)) begin
                        n_pend = {4'd0, hex_val(i_char)};
                        n_mode = MODE_HEX1;
                    end else begin
                        tc_go = 1'b1;
                    end
                end
                MODE_HEX1: begin
                    n_mode = MODE_TEXT;
                    e0_v   = 1'b1;
                    if (is_hex(i_char)) begin
                        e0_d = {r_pend[3:0], hex_val(i_char)};
                    end else begin
                        tc_go = 1'b1;
                    end
                end
                MODE_OCT1, MODE_OCT2: begin
                    if (is_oct) begin
                        n_pend = oct9[7:0];
                        if (r_mode == MODE_OCT1) begin
                            n_mode = MODE_OCT2;
                        end else begin
                            n_mode = MODE_TEXT;
                            e0_v   = 1'b1;
                            e0_d   = oct9[7:0];
                        end
                    end else begin
                        n_mode = MODE_TEXT;
                        e0_v   = 1'b1;
                        tc_go  = 1'b1;
                    end
                end
                default: begin
                    tc_go = 1'b1;
                end
            endcase

            after_e0 = cnt_ext + CW'(e0_v);
            if (tc_go) begin
                n_mode = MODE_TEXT;
                if (after_e0 + CW'(1) >= limit) begin
                    n_lim = 1'b1;
                end else if (i_char == CH_BSLASH) begin
                    n_mode = MODE_ESC;
                end else begin
                    tc_v = 1'b1;
                end
            end
            n_count = LIM_W'(after_e0 + CW'(tc_v));

            if (e0_v) begin
                byte0.data_byte  = e0_d;
                byte0.byte_valid = 1'b1;
                byte1.data_byte  = i_char;
                byte1.byte_valid = 1'b1;
                n_res_any = 1'b1;
                n_res_two = tc_v;
            end else begin
                byte0.data_byte  = i_char;
                byte0.byte_valid = 1'b1;
                n_res_any = tc_v;
            end
        end
    end

    always_comb begin
        o_entry.two = n_res_two;
        if (fin && !e0_v) begin
            o_entry.r0 = done_res;
        end else begin
            o_entry.r0 = byte0;
        end
        o_entry.r1 = fin ? done_res : byte1;
    end

    assign o_push = accept && n_res_any;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_TEXT;
            r_pend  <= '0;
            r_count <= '0;
            r_lim   <= 1'b0;
        end else if (accept) begin
            r_mode  <= n_mode;
            r_pend  <= n_pend;
            r_count <= n_count;
            r_lim   <= n_lim;
        end
    end

endmodule

@@ rtl/esd_fifo.sv @@
module esd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  esd_pkg::t_entry i_entry,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output esd_pkg::t_entry o_head
);
    import esd_pkg::*;

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
        end
    end

endmodule

@@ rtl/esd_back.sv @@
module esd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  esd_pkg::t_entry i_head,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output esd_pkg::t_res   o_res,
    output logic            o_last
);
    import esd_pkg::*;

    logic r_phase;
    logic r_valid;
    t_res r_res;
    logic r_last;
    logic load;
    logic fin;

    assign load  = (!r_valid || i_ready) && !i_empty;
    assign fin   = r_phase || !i_head.two;
    assign o_pop = load && fin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_phase <= !fin;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= r_phase ? i_head.r1 : i_head.r0;
            r_last <= fin;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
    assign o_last  = r_last;

endmodule

@@ rtl/escape_sequence_decoder_top.sv @@
// Path: a request's results are written into the queue when it is accepted and then pass
// through the output register before they are offered on the master side.
// Throughput: one request per cycle while the queue is not full and each request yields at most
// one result; a request that yields two results sends them in turn, absorbed by a four-entry queue.
// Reset: i_rst_n is synchronous and active low; it clears the decoder state and the queue
// and sets buffer_size to MAX_BUFFER_SIZE.
module escape_sequence_decoder_top #(
    parameter int MAX_BUFFER_SIZE = esd_pkg::DEF_MAX_BUFFER_SIZE
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // char_code[7:0]
    input  logic        s_tlast,   // end_of_string
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // data_byte[7:0], decoded_length[19:8], truncated[20]
    output logic [1:0]  m_tuser,   // byte_valid[0], string_done[1]
    output logic        m_tlast,   // last_in_run
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import esd_pkg::*;

    logic [BUF_W-1:0] r_buffer_size;
    logic             push, full, pop, empty;
    t_entry           entry, head;
    t_res             res;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_BUFFER_SIZE) ? {{(32-BUF_W){1'b0}}, r_buffer_size} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_size <= BUF_W'(MAX_BUFFER_SIZE);
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_BUFFER_SIZE) begin
            r_buffer_size <= pwdata[BUF_W-1:0];
        end
    end

    esd_front #(
        .MAX_BUFFER_SIZE(MAX_BUFFER_SIZE)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_tvalid),
        .o_ready       (s_tready),
        .i_char        (s_tdata),
        .i_eos         (s_tlast),
        .i_buffer_size (r_buffer_size),
        .o_push        (push),
        .o_entry       (entry),
        .i_full        (full)
    );

    esd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_head  (head)
    );

    esd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_res   (res),
        .o_last  (m_tlast)
    );

    assign m_tdata = {3'd0, res.truncated, res.decoded_length, res.data_byte};
    assign m_tuser = {res.string_done, res.byte_valid};

endmodule

@@ dv/escape_sequence_decoder_top_tb.sv @@
`timescale 1ns / 100ps

module escape_sequence_decoder_top_tb;

    import esd_pkg::*;

    localparam int MAX_BUF = DEF_MAX_BUFFER_SIZE;
    localparam logic [2:0] ADDR_BUFFER_SIZE = {REG_BUFFER_SIZE, 2'b00};
    localparam logic [2:0] ADDR_UNUSED = 3'd4;

    typedef enum logic [2:0] {
        ST_TEXT,
        ST_ESC,
        ST_HEX_NONE,
        ST_HEX_ONE,
        ST_OCT_ONE,
        ST_OCT_TWO
    } t_dec_state;

    typedef struct packed {
        logic [7:0]  data;
        logic        valid;
        logic        done;
        logic [11:0] len;
        logic        trunc;
        logic        last;
    } t_decoded;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int send_idle_pct = 31;
    int recv_idle_pct = 56;
    int errors = 0;
    int live_items = 0;

    t_dec_state  dec_state;
    logic [7:0]  digit_acc;
    int unsigned out_cnt;
    bit          dropping;
    logic [12:0] buf_size;
    t_decoded    step_out[$];
    t_decoded    decoded_q[$];

    escape_sequence_decoder_top #(
        .MAX_BUFFER_SIZE(MAX_BUF)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 i_clk = ~i_clk;

    initial begin
        #20ms;
        $display("[escape_sequence_decoder_top] ERROR");
        $finish;
    end

    always @(negedge i_clk) begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic note_error(input string msg);
        errors++;
        if (errors <= 10) begin
            $display("%s", msg);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_decoded got;
        t_decoded want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = '0;
            got.data  = m_tdata[7:0];
            got.len   = m_tdata[19:8];
            got.trunc = m_tdata[20];
            got.valid = m_tuser[0];
            got.done  = m_tuser[1];
            got.last  = m_tlast;
            if (decoded_q.size() == 0) begin
                note_error($sformatf("unexpected result data=%02h valid=%0b done=%0b len=%0d",
                                     got.data, got.valid, got.done, got.len));
            end else begin
                want = decoded_q.pop_front();
                if (got !== want) begin
                    note_error($sformatf({"mismatch: expected data=%02h valid=%0b done=%0b ",
                                          "len=%0d trunc=%0b last=%0b, got data=%02h ",
                                          "valid=%0b done=%0b len=%0d trunc=%0b last=%0b"},
                                         want.data, want.valid, want.done, want.len,
                                         want.trunc, want.last, got.data, got.valid,
                                         got.done, got.len, got.trunc, got.last));
                end
            end
        end
    end

    function automatic int hex_digit_value(input logic [7:0] c);
        if (c >= CH_0 && c <= CH_9) return c - CH_0;
        if (c >= CH_LA && c <= CH_LF_) return c - CH_LA + 10;
        if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
        return -1;
    endfunction

    function automatic int unsigned byte_limit();
        return (buf_size > MAX_BUF) ? MAX_BUF : buf_size;
    endfunction

    task automatic emit_byte(input logic [7:0] b);
        t_decoded r;
        r = '0;
        r.data  = b;
        r.valid = 1'b1;
        step_out.push_back(r);
        out_cnt++;
    endtask

    task automatic text_char(input logic [7:0] c);
        dec_state = ST_TEXT;
        if (out_cnt + 1 >= byte_limit()) begin
            dropping = 1'b1;
        end else if (c == CH_BSLASH) begin
            dec_state = ST_ESC;
        end else begin
            emit_byte(c);
        end
    endtask

    task automatic decode_char(input logic [7:0] c, input logic last);
        int h;
        t_decoded r;
        step_out.delete();
        if (last || c == CH_NUL) begin
            if (dec_state == ST_HEX_ONE || dec_state == ST_OCT_ONE || dec_state == ST_OCT_TWO) begin
                emit_byte(digit_acc);
            end
            r = '0;
            r.done  = 1'b1;
            r.len   = out_cnt[11:0];
            r.trunc = dropping;
            step_out.push_back(r);
            dec_state = ST_TEXT;
            digit_acc = '0;
            out_cnt   = 0;
            dropping  = 1'b0;
        end else if (!dropping) begin
            h = hex_digit_value(c);
            case (dec_state)
                ST_ESC: begin
                    dec_state = ST_TEXT;
                    if (c == CH_BSLASH || c == CH_QUOTE) begin
                        emit_byte(c);
                    end else if (c == CH_N) begin
                        emit_byte(BYTE_LF);
                    end else if (c == CH_R) begin
                        emit_byte(BYTE_CR);
                    end else if (c == CH_T) begin
                        emit_byte(BYTE_TAB);
                    end else if (c == CH_E) begin
                        emit_byte(BYTE_ESC);
                    end else if (c == CH_X) begin
                        dec_state = ST_HEX_NONE;
                    end else if (c >= CH_0 && c <= CH_7) begin
                        digit_acc = {5'd0, c[2:0]};
                        dec_state = ST_OCT_ONE;
                    end else begin
                        text_char(c);
                    end
                end
                ST_HEX_NONE: begin
                    if (h >= 0) begin
                        digit_acc = h[7:0];
                        dec_state = ST_HEX_ONE;
                    end else begin
                        text_char(c);
                    end
                end
                ST_HEX_ONE: begin
                    dec_state = ST_TEXT;
                    if (h >= 0) begin
                        emit_byte({digit_acc[3:0], h[3:0]});
                    end else begin
                        emit_byte(digit_acc);
                        text_char(c);
                    end
                end
                ST_OCT_ONE, ST_OCT_TWO: begin
                    if (c >= CH_0 && c <= CH_7) begin
                        digit_acc = {digit_acc[4:0], c[2:0]};
                        if (dec_state == ST_OCT_ONE) begin
                            dec_state = ST_OCT_TWO;
                        end else begin
                            dec_state = ST_TEXT;
                            emit_byte(digit_acc);
                        end
                    end else begin
                        dec_state = ST_TEXT;
                        emit_byte(digit_acc);
                        text_char(c);
                    end
                end
                default: begin
                    text_char(c);
                end
            endcase
        end
        if (step_out.size() > 0) begin
            r = step_out.pop_back();
            r.last = 1'b1;
            step_out.push_back(r);
        end
        foreach (step_out[i]) begin
            decoded_q.push_back(step_out[i]);
        end
    endtask

    task automatic send_char(input logic [7:0] c, input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = c;
        s_tlast  = last;
        do @(posedge i_clk); while (!s_tready);
        if (!dropping || last || c == CH_NUL) begin
            live_items++;
        end
        decode_char(c, last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], 1'b0);
        end
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_tvalid = 1'b0;
        while (decoded_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == ADDR_BUFFER_SIZE) begin
            buf_size = data[12:0];
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
        logic [31:0] got;
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (got !== want) begin
            note_error($sformatf("register read at %0d: expected %08h, got %08h",
                                 addr, want, got));
        end
    endtask

    task automatic set_buffer_size(input logic [12:0] val);
        logic [18:0] junk;
        junk = 19'($urandom);
        wait_idle();
        apb_write(ADDR_BUFFER_SIZE, {junk, val});
        apb_read_check(ADDR_BUFFER_SIZE, {19'd0, buf_size});
    endtask

    function automatic logic [7:0] random_hex_digit();
        case ($urandom_range(2))
            0:       return CH_0 + 8'($urandom_range(9));
            1:       return CH_LA + 8'($urandom_range(5));
            default: return CH_UA + 8'($urandom_range(5));
        endcase
    endfunction

    task automatic send_token();
        int pick;
        pick = $urandom_range(99);
        if (pick < 40) begin
            send_char(8'($urandom_range(1, 255)), 1'b0);
        end else if (pick < 55) begin
            send_char(CH_BSLASH, 1'b0);
            case ($urandom_range(5))
                0: send_char(CH_BSLASH, 1'b0);
                1: send_char(CH_QUOTE, 1'b0);
                2: send_char(CH_N, 1'b0);
                3: send_char(CH_R, 1'b0);
                4: send_char(CH_T, 1'b0);
                default: send_char(CH_E, 1'b0);
            endcase
        end else if (pick < 70) begin
            send_char(CH_BSLASH, 1'b0);
            send_char(CH_X, 1'b0);
            repeat ($urandom_range(2)) send_char(random_hex_digit(), 1'b0);
        end else if (pick < 85) begin
            send_char(CH_BSLASH, 1'b0);
            repeat ($urandom_range(1, 3)) send_char(CH_0 + 8'($urandom_range(7)), 1'b0);
        end else begin
            send_char(CH_BSLASH, 1'b0);
            send_char(8'($urandom_range(255)), 1'b0);
        end
    endtask

    task automatic send_string();
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 20)) begin
                send_char(8'($urandom_range(255)), ($urandom_range(7) == 0));
            end
        end else begin
            repeat ($urandom_range(12)) send_token();
        end
        if ($urandom_range(1)) begin
            send_char(8'($urandom_range(255)), 1'b1);
        end else begin
            send_char(CH_NUL, 1'b0);
        end
    endtask

    function automatic logic [12:0] random_buffer_size();
        case ($urandom_range(9))
            0:       return 13'($urandom_range(3));
            1:       return 13'($urandom_range(MAX_BUF, 8191));
            default: return 13'($urandom_range(3, 48));
        endcase
    endfunction

    task automatic test_directed();
        send_char(8'h01, 1'b0);
        send_char(8'hFF, 1'b0);
        send_text("\\e\\x4F\\xaZ\\377\\xG\\7");
        send_char(8'hFF, 1'b1);
        send_char(CH_BSLASH, 1'b0);
        send_char(CH_NUL, 1'b0);
    endtask

    task automatic test_small_buffers();
        set_buffer_size(13'd0);
        send_text("ab");
        send_char(CH_NUL, 1'b1);
        set_buffer_size(13'd1);
        send_text("a");
        send_char(CH_NUL, 1'b0);
        set_buffer_size(13'd2);
        send_text("abc");
        send_char(8'h41, 1'b1);
        wait_idle();
        apb_write(ADDR_UNUSED, 32'h0000_0005);
        apb_read_check(ADDR_BUFFER_SIZE, {19'd0, buf_size});
    endtask

    task automatic test_random(input int send_pct, input int recv_pct, input int n_items);
        int target;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        target = live_items + n_items;
        while (live_items < target) begin
            set_buffer_size(random_buffer_size());
            repeat ($urandom_range(3, 10)) send_string();
        end
    endtask

    task automatic test_long_strings();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_buffer_size(13'd8191);
        repeat (150) send_char(8'($urandom_range(1, 255)), 1'b0);
        send_char(CH_NUL, 1'b1);
        set_buffer_size(13'd100);
        repeat (150) send_char(8'($urandom_range(1, 255)), 1'b0);
        send_char(CH_NUL, 1'b0);
    endtask

    initial begin
        i_rst_n   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tlast   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        dec_state = ST_TEXT;
        digit_acc = '0;
        out_cnt   = 0;
        dropping  = 1'b0;
        buf_size  = 13'(MAX_BUF);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_small_buffers();
        test_random(31, 56, 400);
        test_random(56, 31, 400);
        test_random(0, 0, 400);
        test_long_strings();
        wait_idle();

        if (errors == 0) begin
            $display("[escape_sequence_decoder_top] OK");
        end else begin
            $display("[escape_sequence_decoder_top] ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/esd_pkg.sv
rtl/esd_front.sv
rtl/esd_fifo.sv
rtl/esd_back.sv
rtl/escape_sequence_decoder_top.sv
dv/escape_sequence_decoder_top_tb.sv
